// ===== rtl/nds_pkg.sv =====
// Types, codes and arithmetic helpers shared by the nearest direction select block.
package nds_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int LIM_SHIFT      = 28;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    localparam logic [2:0] LAST_OP_NQ   = 3'd2;
    localparam logic [2:0] LAST_OP_SLOT = 3'd5;
    localparam logic [2:0] LAST_OP_CMP  = 3'd5;
    localparam logic [2:0] LAST_OP_LIM  = 3'd4;

    typedef struct packed {
        logic                             action;
        logic [3:0]                       slot;
        logic signed [COMPONENT_BITS-1:0] vec_x;
        logic signed [COMPONENT_BITS-1:0] vec_y;
        logic signed [COMPONENT_BITS-1:0] vec_z;
        logic [4:0]                       choice_count;
        logic                             limit_enable;
        logic signed [15:0]               limit_cos;
        logic                             symmetric;
    } cmd_t;

    typedef struct packed {
        logic [3:0] best_index;
        logic       found;
        logic       negated;
    } result_t;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] x;
        logic signed [COMPONENT_BITS-1:0] y;
        logic signed [COMPONENT_BITS-1:0] z;
    } vec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NQ,
        ST_NEXT,
        ST_LATCH,
        ST_SLOT,
        ST_CHECK,
        ST_CMP,
        ST_DECIDE,
        ST_LIM,
        ST_LCHK,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_NQ,
        ACT_NC,
        ACT_DP,
        ACT_SQ,
        ACT_ALO_A,
        ACT_AHI_A,
        ACT_ALO_B,
        ACT_AHI_B
    } act_t;

    function automatic logic [31:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = v[15] ? -{v[15], v} : {v[15], v};
        return {15'b0, w};
    endfunction

    function automatic logic [31:0] mag34(input logic signed [33:0] v);
        logic signed [33:0] w;
        w = v[33] ? -v : v;
        return w[31:0];
    endfunction

    function automatic logic signed [1:0] sgn34(input logic signed [33:0] v);
        return (v == '0) ? 2'sd0 : (v[33] ? -2'sd1 : 2'sd1);
    endfunction

    function automatic logic signed [1:0] sgn16(input logic signed [15:0] v);
        return (v == '0) ? 2'sd0 : (v[15] ? -2'sd1 : 2'sd1);
    endfunction

    // sa*a > sb*b, signs in {-1,0,1}
    function automatic logic gt96(input logic signed [1:0] sa, input logic [95:0] a,
                                  input logic signed [1:0] sb, input logic [95:0] b);
        logic r;
        if (sa != sb)
            r = (sa > sb);
        else if (sa == 2'sd0)
            r = 1'b0;
        else if (sa > 2'sd0)
            r = (a > b);
        else
            r = (a < b);
        return r;
    endfunction

endpackage

// ===== rtl/nearest_direction_select.sv =====
// Nearest direction select: slot table of 3-D vectors and a best-cosine search over it.
//
// A load beat writes the vector into its slot, and busy stays low.
// A query beat raises busy until the result strobe. All products go through one shared
// 32x32 multiplier, each product in an issue step and then an accumulate step. A query
// first forms the squared norm of its direction, then for each searched slot and pass
// forms the slot's norm and dot product, then, when the slot must be compared against
// the current pick rather than taken or skipped, a comparison; it closes each pass, runs
// the limit check when enabled, and then gives the result.
// The result shows in the single cycle that done is high and holds until the next query.
// A query that reads a slot never loaded gives an undefined result.
module nearest_direction_select #(
    parameter int MAX_CHOICES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nds_pkg::cmd_t     cmd,
    output logic              done,
    output nds_pkg::result_t  result
);

    localparam int AW    = (MAX_CHOICES > 1) ? $clog2(MAX_CHOICES) : 1;
    localparam int CNT_W = $clog2(MAX_CHOICES + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

    nds_pkg::state_t state_reg, state_next;
    nds_pkg::act_t   act_reg, act_next, op_act;
    logic [2:0]      op_reg, op_next, last_op;
    logic            ph_reg, ph_next;
    logic            have_reg, have_next;
    logic            pass_reg, pass_next;
    logic            op_done, in_mult;

    nds_pkg::vec_t      q_reg, q_next, c_reg, c_next, rd_reg;
    logic [CW-1:0]      cnt_reg, cnt_next, idx_reg, idx_next;
    logic [AW-1:0]      best_i_reg, best_i_next;
    logic               opp_reg, opp_next, sym_reg, sym_next, lim_en_reg, lim_en_next;
    logic signed [15:0] lim_reg, lim_next;
    logic [31:0]        nq_reg, nq_next, nc_reg, nc_next, best_n_reg, best_n_next;
    logic signed [33:0] d_reg, d_next, best_d_reg, best_d_next;
    logic [63:0]        sq_reg, sq_next, prod_reg;
    logic [95:0]        acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic               neg_reg, neg_next, op_neg;
    logic [31:0]        mul_a, mul_b;
    logic               take;

    logic [3*nds_pkg::COMPONENT_BITS-1:0] mem [MAX_CHOICES];
    logic                                 wr_en;

    assign in_mult = (state_reg == nds_pkg::ST_NQ) || (state_reg == nds_pkg::ST_SLOT) ||
                     (state_reg == nds_pkg::ST_CMP) || (state_reg == nds_pkg::ST_LIM);
    assign op_done = in_mult && ph_reg && (op_reg == last_op);
    assign wr_en   = (state_reg == nds_pkg::ST_IDLE) && start &&
                     (cmd.action == nds_pkg::ACTION_LOAD) &&
                     ({{(CW-4){1'b0}}, cmd.slot} < CW'(MAX_CHOICES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(cmd.slot)] <= {cmd.vec_x, cmd.vec_y, cmd.vec_z};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nds_pkg::ST_IDLE:
                if (start && cmd.action == nds_pkg::ACTION_QUERY)
                    state_next = nds_pkg::ST_NQ;
            nds_pkg::ST_NQ:
                if (op_done)
                    state_next = nds_pkg::ST_NEXT;
            nds_pkg::ST_NEXT:
                if (nq_reg == '0)
                    state_next = nds_pkg::ST_DONE;
                else if (idx_reg == cnt_reg)
                begin
                    if (sym_reg && !pass_reg)
                        state_next = nds_pkg::ST_NEXT;
                    else if (have_reg && lim_en_reg)
                        state_next = nds_pkg::ST_LIM;
                    else
                        state_next = nds_pkg::ST_DONE;
                end
                else
                    state_next = nds_pkg::ST_LATCH;
            nds_pkg::ST_LATCH:
                state_next = nds_pkg::ST_SLOT;
            nds_pkg::ST_SLOT:
                if (op_done)
                    state_next = nds_pkg::ST_CHECK;
            nds_pkg::ST_CHECK:
                if (nc_reg == '0 || !have_reg)
                    state_next = nds_pkg::ST_NEXT;
                else
                    state_next = nds_pkg::ST_CMP;
            nds_pkg::ST_CMP:
                if (op_done)
                    state_next = nds_pkg::ST_DECIDE;
            nds_pkg::ST_DECIDE:
                state_next = nds_pkg::ST_NEXT;
            nds_pkg::ST_LIM:
                if (op_done)
                    state_next = nds_pkg::ST_LCHK;
            nds_pkg::ST_LCHK:
                state_next = nds_pkg::ST_DONE;
            nds_pkg::ST_DONE:
                state_next = nds_pkg::ST_IDLE;
            default:
                state_next = nds_pkg::ST_IDLE;
        endcase
    end

    // outputs and multiplier operand selection
    always_comb
    begin
        busy    = (state_reg != nds_pkg::ST_IDLE);
        done    = (state_reg == nds_pkg::ST_DONE);
        result.found       = have_reg;
        result.best_index  = have_reg ? 4'(best_i_reg) : 4'd0;
        result.negated     = have_reg && opp_reg;

        mul_a   = '0;
        mul_b   = '0;
        op_act  = nds_pkg::ACT_NONE;
        op_neg  = 1'b0;
        last_op = '0;
        case (state_reg)
            nds_pkg::ST_NQ:
            begin
                last_op = nds_pkg::LAST_OP_NQ;
                op_act  = nds_pkg::ACT_NQ;
                case (op_reg)
                    3'd0:    mul_a = nds_pkg::mag16(q_reg.x);
                    3'd1:    mul_a = nds_pkg::mag16(q_reg.y);
                    default: mul_a = nds_pkg::mag16(q_reg.z);
                endcase
                mul_b = mul_a;
            end
            nds_pkg::ST_SLOT:
            begin
                last_op = nds_pkg::LAST_OP_SLOT;
                case (op_reg)
                    3'd0:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.x); mul_b = mul_a;
                        op_act = nds_pkg::ACT_NC;
                    end
                    3'd1:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.y); mul_b = mul_a;
                        op_act = nds_pkg::ACT_NC;
                    end
                    3'd2:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.z); mul_b = mul_a;
                        op_act = nds_pkg::ACT_NC;
                    end
                    3'd3:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.x); mul_b = nds_pkg::mag16(q_reg.x);
                        op_act = nds_pkg::ACT_DP; op_neg = c_reg.x[15] ^ q_reg.x[15] ^ pass_reg;
                    end
                    3'd4:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.y); mul_b = nds_pkg::mag16(q_reg.y);
                        op_act = nds_pkg::ACT_DP; op_neg = c_reg.y[15] ^ q_reg.y[15] ^ pass_reg;
                    end
                    default:
                    begin
                        mul_a = nds_pkg::mag16(c_reg.z); mul_b = nds_pkg::mag16(q_reg.z);
                        op_act = nds_pkg::ACT_DP; op_neg = c_reg.z[15] ^ q_reg.z[15] ^ pass_reg;
                    end
                endcase
            end
            nds_pkg::ST_CMP:
            begin
                last_op = nds_pkg::LAST_OP_CMP;
                case (op_reg)
                    3'd0:
                    begin
                        mul_a = nds_pkg::mag34(d_reg); mul_b = mul_a;
                        op_act = nds_pkg::ACT_SQ;
                    end
                    3'd1:
                    begin
                        mul_a = sq_reg[31:0]; mul_b = best_n_reg; op_act = nds_pkg::ACT_ALO_A;
                    end
                    3'd2:
                    begin
                        mul_a = sq_reg[63:32]; mul_b = best_n_reg; op_act = nds_pkg::ACT_AHI_A;
                    end
                    3'd3:
                    begin
                        mul_a = nds_pkg::mag34(best_d_reg); mul_b = mul_a;
                        op_act = nds_pkg::ACT_SQ;
                    end
                    3'd4:
                    begin
                        mul_a = sq_reg[31:0]; mul_b = nc_reg; op_act = nds_pkg::ACT_ALO_B;
                    end
                    default:
                    begin
                        mul_a = sq_reg[63:32]; mul_b = nc_reg; op_act = nds_pkg::ACT_AHI_B;
                    end
                endcase
            end
            nds_pkg::ST_LIM:
            begin
                last_op = nds_pkg::LAST_OP_LIM;
                case (op_reg)
                    3'd0:
                    begin
                        mul_a = nds_pkg::mag16(lim_reg); mul_b = mul_a;
                        op_act = nds_pkg::ACT_SQ;
                    end
                    3'd1:
                    begin
                        mul_a = sq_reg[31:0]; mul_b = best_n_reg; op_act = nds_pkg::ACT_SQ;
                    end
                    3'd2:
                    begin
                        mul_a = sq_reg[31:0]; mul_b = nq_reg; op_act = nds_pkg::ACT_ALO_B;
                    end
                    3'd3:
                    begin
                        mul_a = sq_reg[63:32]; mul_b = nq_reg; op_act = nds_pkg::ACT_AHI_B;
                    end
                    default:
                    begin
                        mul_a = nds_pkg::mag34(best_d_reg); mul_b = mul_a;
                        op_act = nds_pkg::ACT_ALO_A;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign take = (state_reg == nds_pkg::ST_CHECK && nc_reg != '0 && !have_reg) ||
                  (state_reg == nds_pkg::ST_DECIDE &&
                   nds_pkg::gt96(nds_pkg::sgn34(d_reg), acc_a_reg,
                                 nds_pkg::sgn34(best_d_reg), acc_b_reg));

    // datapath and sequencer counters
    always_comb
    begin
        ph_next     = ph_reg;
        op_next     = op_reg;
        act_next    = nds_pkg::ACT_NONE;
        neg_next    = neg_reg;
        have_next   = have_reg;
        pass_next   = pass_reg;
        q_next      = q_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        best_i_next = best_i_reg;
        opp_next    = opp_reg;
        sym_next    = sym_reg;
        lim_en_next = lim_en_reg;
        lim_next    = lim_reg;
        nq_next     = nq_reg;
        nc_next     = nc_reg;
        best_n_next = best_n_reg;
        d_next      = d_reg;
        best_d_next = best_d_reg;
        sq_next     = sq_reg;
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;

        // issue on phase 0, accumulate on phase 1
        if (in_mult)
        begin
            if (!ph_reg)
            begin
                act_next = op_act;
                neg_next = op_neg;
                ph_next  = 1'b1;
            end
            else
            begin
                ph_next = 1'b0;
                op_next = (op_reg == last_op) ? 3'd0 : op_reg + 3'd1;
            end
        end

        case (act_reg)
            nds_pkg::ACT_NQ:    nq_next = nq_reg + prod_reg[31:0];
            nds_pkg::ACT_NC:    nc_next = nc_reg + prod_reg[31:0];
            nds_pkg::ACT_DP:    d_next  = neg_reg ? d_reg - $signed({2'b0, prod_reg[31:0]})
                                                  : d_reg + $signed({2'b0, prod_reg[31:0]});
            nds_pkg::ACT_SQ:    sq_next = prod_reg;
            nds_pkg::ACT_ALO_A: acc_a_next = {32'b0, prod_reg};
            nds_pkg::ACT_AHI_A: acc_a_next = acc_a_reg + {prod_reg, 32'b0};
            nds_pkg::ACT_ALO_B: acc_b_next = {32'b0, prod_reg};
            nds_pkg::ACT_AHI_B: acc_b_next = acc_b_reg + {prod_reg, 32'b0};
            default:            sq_next = sq_reg;
        endcase

        case (state_reg)
            nds_pkg::ST_IDLE:
                if (start && cmd.action == nds_pkg::ACTION_QUERY)
                begin
                    q_next      = '{x: cmd.vec_x, y: cmd.vec_y, z: cmd.vec_z};
                    cnt_next    = (CW'(cmd.choice_count) > CW'(MAX_CHOICES)) ?
                                  CW'(MAX_CHOICES) : CW'(cmd.choice_count);
                    lim_en_next = cmd.limit_enable;
                    lim_next    = cmd.limit_cos;
                    sym_next    = cmd.symmetric;
                    nq_next     = '0;
                    have_next   = 1'b0;
                    opp_next    = 1'b0;
                    pass_next   = 1'b0;
                    idx_next    = '0;
                    best_i_next = '0;
                    ph_next     = 1'b0;
                    op_next     = '0;
                end
            nds_pkg::ST_NEXT:
                if (idx_reg == cnt_reg && sym_reg && !pass_reg)
                begin
                    pass_next = 1'b1;
                    idx_next  = '0;
                end
            nds_pkg::ST_LATCH:
            begin
                c_next  = rd_reg;
                nc_next = '0;
                d_next  = '0;
            end
            nds_pkg::ST_CHECK:
                if (nc_reg == '0 || !have_reg)
                    idx_next = idx_reg + CW'(1);
            nds_pkg::ST_DECIDE:
                idx_next = idx_reg + CW'(1);
            nds_pkg::ST_LCHK:
                // drop a pick whose cosine falls below the limit
                if (nds_pkg::gt96(nds_pkg::sgn16(lim_reg), acc_b_reg,
                                  nds_pkg::sgn34(best_d_reg),
                                  acc_a_reg << nds_pkg::LIM_SHIFT))
                    have_next = 1'b0;
            default:
                have_next = have_next;
        endcase

        if (take)
        begin
            have_next   = 1'b1;
            best_i_next = idx_reg[AW-1:0];
            best_d_next = d_reg;
            best_n_next = nc_reg;
            opp_next    = pass_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nds_pkg::ST_IDLE;
            act_reg   <= nds_pkg::ACT_NONE;
            op_reg    <= '0;
            ph_reg    <= 1'b0;
            have_reg  <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            op_reg    <= op_next;
            ph_reg    <= ph_next;
            have_reg  <= have_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= {32'b0, mul_a} * {32'b0, mul_b};
        neg_reg    <= neg_next;
        q_reg      <= q_next;
        c_reg      <= c_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        best_i_reg <= best_i_next;
        opp_reg    <= opp_next;
        sym_reg    <= sym_next;
        lim_en_reg <= lim_en_next;
        lim_reg    <= lim_next;
        nq_reg     <= nq_next;
        nc_reg     <= nc_next;
        best_n_reg <= best_n_next;
        d_reg      <= d_next;
        best_d_reg <= best_d_next;
        sq_reg     <= sq_next;
        acc_a_reg  <= acc_a_next;
        acc_b_reg  <= acc_b_next;
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a query");
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("block still busy after result beat");
    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.best_index == 4'd0 && !result.negated)
        else $error("not-found result carries a slot or negated flag");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == nds_pkg::ACTION_QUERY |=> busy && !done)
        else $error("query beat did not start a search");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == nds_pkg::ACTION_LOAD |=> !busy)
        else $error("load beat left the block busy");

endmodule
